// File: design/kmst_pkg.sv
package kmst_pkg;

    localparam int MAX_EDGES    = 32;
    localparam int MAX_VERTICES = 32;

    localparam int EIDX_W = $clog2(MAX_EDGES);
    localparam int ECNT_W = $clog2(MAX_EDGES + 1);
    localparam int VIDX_W = 5;
    localparam int VCNT_W = 6;
    localparam int WGT_W  = 16;
    localparam int COST_W = 21;

    localparam logic [VCNT_W-1:0] VERTEX_COUNT_RST = VCNT_W'(32);
    localparam logic [VCNT_W-1:0] VERTEX_LIMIT     = VCNT_W'(MAX_VERTICES);
    localparam logic [VIDX_W-1:0] CLEAR_LAST       = VIDX_W'(MAX_VERTICES - 1);

    localparam logic REG_VERTEX_COUNT = 1'b0;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic clr_step;
        logic fetch;
        logic hop;
        logic swap;
        logic skip;
        logic link;
        logic emit_sum;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic in_last;
        logic clr_done;
        logic walk_end;
        logic out_range;
        logic is_root;
        logic same_root;
        logic out_free;
    } t_status;

endpackage

// File: design/kruskal_mst_union_find.sv
// Minimum spanning tree by Kruskal's method.
// Input channel (i_in_valid / o_in_stall): one edge word per cycle while
// loading. Each word is inserted into a weight-ordered edge line at once,
// ties keeping arrival order; words beyond 32 stored edges are dropped.
// The word with i_edge_last set starts the run and the input stalls until
// the summary word has been handed to the output register.
// A run first clears all 32 entries of the parent table, then walks the
// edge line: each edge visited is fetched and range-checked, and an edge
// in range has both endpoints chased to their roots, one parent hop at a
// time through the registered parent table read port; an edge whose roots
// differ is kept. The walk then ends and the summary word is handed on.
// Output channel (o_out_valid / i_out_stall): one word per kept edge with
// the running cost, then a summary word with o_run_last set. A stalled
// word holds in the output register and the walk waits for it.
// Reset empties the edge line, sets the vertex count to 32 and drops any
// pending output. The vertex count register sits at APB address 0.
module kruskal_mst_union_find
    import kmst_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [VIDX_W-1:0]        i_edge_src,
    input  logic [VIDX_W-1:0]        i_edge_dst,
    input  logic signed [WGT_W-1:0]  i_edge_weight,
    input  logic                     i_edge_last,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_is_edge,
    output logic [VIDX_W-1:0]        o_tree_src,
    output logic [VIDX_W-1:0]        o_tree_dst,
    output logic signed [WGT_W-1:0]  o_tree_weight,
    output logic signed [COST_W-1:0] o_total_cost,
    output logic                     o_run_last
);

    logic [VCNT_W-1:0] r_vertex_count;
    t_cmd              w_cmd;
    t_status           w_status;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VERTEX_COUNT_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_VERTEX_COUNT) begin
            r_vertex_count <= pwdata[VCNT_W-1:0];
        end
    end
    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {{(32-VCNT_W){1'b0}}, r_vertex_count}
                                                    : '0;

    kmst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    kmst_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_vertex_count (r_vertex_count),
        .i_edge_src     (i_edge_src),
        .i_edge_dst     (i_edge_dst),
        .i_edge_weight  (i_edge_weight),
        .i_edge_last    (i_edge_last),
        .i_out_stall    (i_out_stall),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .o_is_edge      (o_is_edge),
        .o_tree_src     (o_tree_src),
        .o_tree_dst     (o_tree_dst),
        .o_tree_weight  (o_tree_weight),
        .o_total_cost   (o_total_cost),
        .o_run_last     (o_run_last)
    );

endmodule

// File: design/kmst_ctrl.sv
module kmst_ctrl
    import kmst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    typedef enum logic [9:0] {
        S_LOAD  = 10'b0000000001,
        S_CLEAR = 10'b0000000010,
        S_WALK  = 10'b0000000100,
        S_CHECK = 10'b0000001000,
        S_RDU   = 10'b0000010000,
        S_CHKU  = 10'b0000100000,
        S_RDV   = 10'b0001000000,
        S_CHKV  = 10'b0010000000,
        S_EMIT  = 10'b0100000000,
        S_SUM   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_LOAD);

    // sequence load, clear pass, walk and result words
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.in_last) n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_done) n_state = S_WALK;
            end
            S_WALK: begin
                if (i_status.walk_end) begin
                    n_state = S_SUM;
                end else begin
                    o_cmd.fetch = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.out_range) begin
                    o_cmd.skip = 1'b1;
                    n_state    = S_WALK;
                end else begin
                    n_state = S_RDU;
                end
            end
            S_RDU: n_state = S_CHKU;
            S_CHKU: begin
                if (i_status.is_root) begin
                    o_cmd.swap = 1'b1;
                    n_state    = S_RDV;
                end else begin
                    o_cmd.hop = 1'b1;
                    n_state   = S_RDU;
                end
            end
            S_RDV: n_state = S_CHKV;
            S_CHKV: begin
                if (!i_status.is_root) begin
                    o_cmd.hop = 1'b1;
                    n_state   = S_RDV;
                end else if (i_status.same_root) begin
                    o_cmd.skip = 1'b1;
                    n_state    = S_WALK;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.link = 1'b1;
                    o_cmd.skip = 1'b1;
                    n_state    = S_WALK;
                end
            end
            S_SUM: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sum = 1'b1;
                    n_state        = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

endmodule

// File: design/kmst_dp.sv
module kmst_dp
    import kmst_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [VCNT_W-1:0]        i_vertex_count,
    input  logic [VIDX_W-1:0]        i_edge_src,
    input  logic [VIDX_W-1:0]        i_edge_dst,
    input  logic signed [WGT_W-1:0]  i_edge_weight,
    input  logic                     i_edge_last,
    input  logic                     i_out_stall,
    output t_status                  o_status,
    output logic                     o_out_valid,
    output logic                     o_is_edge,
    output logic [VIDX_W-1:0]        o_tree_src,
    output logic [VIDX_W-1:0]        o_tree_dst,
    output logic signed [WGT_W-1:0]  o_tree_weight,
    output logic signed [COST_W-1:0] o_total_cost,
    output logic                     o_run_last
);

    // sorted edge line, kept in weight order as words arrive
    logic [VIDX_W-1:0]       r_cs [MAX_EDGES];
    logic [VIDX_W-1:0]       r_cd [MAX_EDGES];
    logic signed [WGT_W-1:0] r_cw [MAX_EDGES];
    logic [ECNT_W-1:0]       r_n;
    logic [MAX_EDGES-1:0]    w_gt;

    // parent table
    logic [VIDX_W-1:0] r_parent [MAX_VERTICES];
    logic [VIDX_W-1:0] r_rd;
    logic [VIDX_W-1:0] r_clr;

    // walk registers
    logic [ECNT_W-1:0]       r_i;
    logic [VCNT_W-1:0]       r_chosen;
    logic signed [COST_W-1:0] r_cost;
    logic [VIDX_W-1:0]       r_es, r_ed, r_cur, r_ru;
    logic signed [WGT_W-1:0] r_ew;
    logic [VCNT_W-1:0]       w_nv;
    logic                    w_full;
    logic signed [COST_W-1:0] w_cost_next;

    assign w_full = (r_n == ECNT_W'(MAX_EDGES));
    assign w_nv   = (i_vertex_count > VERTEX_LIMIT) ? VERTEX_LIMIT : i_vertex_count;
    assign w_cost_next = r_cost + COST_W'(r_ew);

    always_comb begin
        for (int k = 0; k < MAX_EDGES; k++) begin
            w_gt[k] = (ECNT_W'(k) < r_n) && (r_cw[k] > i_edge_weight);
        end
    end

    // insert new word behind all entries of equal or lower weight
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !w_full) begin
            for (int k = 0; k < MAX_EDGES; k++) begin
                if (k > 0 && w_gt[(k > 0) ? k - 1 : 0]) begin
                    r_cs[k] <= r_cs[(k > 0) ? k - 1 : 0];
                    r_cd[k] <= r_cd[(k > 0) ? k - 1 : 0];
                    r_cw[k] <= r_cw[(k > 0) ? k - 1 : 0];
                end else if (w_gt[k] || ECNT_W'(k) == r_n) begin
                    r_cs[k] <= i_edge_src;
                    r_cd[k] <= i_edge_dst;
                    r_cw[k] <= i_edge_weight;
                end
            end
        end
    end

    // count stored edges; restart after the summary word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
        end else if (i_cmd.emit_sum) begin
            r_n <= '0;
        end else if (i_cmd.load && !w_full) begin
            r_n <= r_n + 1'b1;
        end
    end

    // parent table write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_parent[r_clr] <= r_clr;
        end else if (i_cmd.link) begin
            r_parent[r_ru] <= r_cur;
        end
        r_rd <= r_parent[r_cur];
    end

    // clear sweep index and walk counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_i      <= '0;
            r_chosen <= '0;
            r_cost   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_clr    <= '0;
                r_i      <= '0;
                r_chosen <= '0;
                r_cost   <= '0;
            end
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.skip)     r_i   <= r_i + 1'b1;
            if (i_cmd.link) begin
                r_chosen <= r_chosen + 1'b1;
                r_cost   <= w_cost_next;
            end
        end
    end

    // latch current edge and chase roots
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_es  <= r_cs[r_i[EIDX_W-1:0]];
            r_ed  <= r_cd[r_i[EIDX_W-1:0]];
            r_ew  <= r_cw[r_i[EIDX_W-1:0]];
            r_cur <= r_cs[r_i[EIDX_W-1:0]];
        end else if (i_cmd.hop) begin
            r_cur <= r_rd;
        end else if (i_cmd.swap) begin
            r_ru  <= r_cur;
            r_cur <= r_ed;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.link || i_cmd.emit_sum) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.link) begin
            o_is_edge     <= 1'b1;
            o_tree_src    <= r_es;
            o_tree_dst    <= r_ed;
            o_tree_weight <= r_ew;
            o_total_cost  <= w_cost_next;
            o_run_last    <= 1'b0;
        end else if (i_cmd.emit_sum) begin
            o_is_edge     <= 1'b0;
            o_tree_src    <= '0;
            o_tree_dst    <= '0;
            o_tree_weight <= '0;
            o_total_cost  <= r_cost;
            o_run_last    <= 1'b1;
        end
    end

    assign o_status.in_last   = i_edge_last;
    assign o_status.clr_done  = (r_clr == CLEAR_LAST);
    assign o_status.walk_end  = (r_i >= r_n) || (w_nv <= VCNT_W'(1))
                                || (r_chosen >= w_nv - 1'b1);
    assign o_status.out_range = (VCNT_W'(r_es) >= w_nv) || (VCNT_W'(r_ed) >= w_nv);
    assign o_status.is_root   = (r_rd == r_cur);
    assign o_status.same_root = (r_ru == r_cur);
    assign o_status.out_free  = !o_out_valid || !i_out_stall;

endmodule
